@@ design/mfpp_pkg.sv @@
package mfpp_pkg;

    // Frame store geometry
    localparam int FRAME_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int POS_W       = 12;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd5;

    // Draw mode codes
    localparam logic [1:0] DM_SET    = 2'd0;
    localparam logic [1:0] DM_CLEAR  = 2'd1;
    localparam logic [1:0] DM_INVERT = 2'd2;
    localparam logic [1:0] DM_NONE   = 2'd3;

    // Request type codes
    localparam logic REQ_READ = 1'b0;
    localparam logic REQ_PLOT = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic req_load;
        logic mem_rd;
        logic apply;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } t_status;

endpackage

@@ design/mfpp_ctrl.sv @@
module mfpp_ctrl
    import mfpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_APPLY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_fire) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_APPLY;
            end
            S_APPLY: begin
                // Hold until the output register is free
                if (!i_status.out_busy) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // A lookup always follows an accepted beat
    a_lookup_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP) |-> $past(r_state == S_IDLE && i_in_valid))
        else $error("lookup without accepted request");

endmodule

@@ design/mfpp_datapath.sv @@
module mfpp_datapath
    import mfpp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int ROW_BYTES     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data,
    input  logic                 i_req_type,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_pixel_value,
    output logic                 o_pixel_written
);

    localparam int RB_W = $clog2(ROW_BYTES + 1);
    localparam logic signed [POS_W:0] WIDTH_S  = (POS_W + 1)'(SCREEN_WIDTH);
    localparam logic signed [POS_W:0] HEIGHT_S = (POS_W + 1)'(SCREEN_HEIGHT);

    // Configuration registers
    logic [1:0]              r_draw_mode;
    logic                    r_clip_en;
    logic signed [POS_W-1:0] r_clip_left;
    logic signed [POS_W-1:0] r_clip_right;
    logic signed [POS_W-1:0] r_clip_top;
    logic signed [POS_W-1:0] r_clip_bottom;

    // Request registers
    logic              r_plot;
    logic              r_on;
    logic              r_inside;
    logic [ADDR_W-1:0] r_addr;
    logic [2:0]        r_pix_idx;
    logic [7:0]        r_rd_data;

    // Clear sweep and output registers
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_out_valid;
    logic              r_pix_value;
    logic              r_pix_written;

    logic [7:0] r_mem [FRAME_DEPTH];

    logic signed [POS_W:0]   w_x13;
    logic signed [POS_W:0]   w_y13;
    logic signed [POS_W-1:0] w_xs;
    logic signed [POS_W-1:0] w_ys;
    logic                    w_on;
    logic                    w_inside;
    logic [ADDR_W+RB_W-1:0]  w_prod;
    logic [ADDR_W-1:0]       w_addr;
    logic                    w_cur;
    logic                    w_new;
    logic                    w_we;
    logic                    w_value;
    logic [7:0]              w_byte;

    // Bounds, clip and address for an incoming beat
    assign w_xs  = $signed(i_pos_x);
    assign w_ys  = $signed(i_pos_y);
    assign w_x13 = (POS_W + 1)'(w_xs);
    assign w_y13 = (POS_W + 1)'(w_ys);
    assign w_on  = !i_pos_x[POS_W-1] && (w_x13 < WIDTH_S)
                && !i_pos_y[POS_W-1] && (w_y13 < HEIGHT_S);
    assign w_inside = !r_clip_en
                   || ((w_xs >= r_clip_left) && (w_xs <= r_clip_right)
                    && (w_ys >= r_clip_top) && (w_ys <= r_clip_bottom));
    assign w_prod = i_pos_y[ADDR_W-1:0] * RB_W'(ROW_BYTES);
    assign w_addr = w_prod[ADDR_W-1:0] + ADDR_W'(i_pos_x[9:3]);

    // Modify the fetched byte
    assign w_cur = r_rd_data[r_pix_idx];
    always_comb begin
        case (r_draw_mode)
            DM_SET:    w_new = 1'b1;
            DM_CLEAR:  w_new = 1'b0;
            DM_INVERT: w_new = !w_cur;
            default:   w_new = 1'b0;
        endcase
    end
    assign w_we    = (r_plot == REQ_PLOT) && r_on && r_inside && (r_draw_mode != DM_NONE);
    assign w_value = (r_plot == REQ_READ) ? (r_on && w_cur) : (w_we && w_new);
    always_comb begin
        w_byte            = r_rd_data;
        w_byte[r_pix_idx] = w_new;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_mode   <= DM_SET;
            r_clip_en     <= 1'b0;
            r_clip_left   <= 12'sd0;
            r_clip_right  <= 12'sd127;
            r_clip_top    <= 12'sd0;
            r_clip_bottom <= 12'sd63;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                REG_DRAW_MODE:   r_draw_mode   <= i_cfg_data[1:0];
                REG_CLIP_ENABLE: r_clip_en     <= i_cfg_data[0];
                REG_CLIP_LEFT:   r_clip_left   <= $signed(i_cfg_data);
                REG_CLIP_RIGHT:  r_clip_right  <= $signed(i_cfg_data);
                REG_CLIP_TOP:    r_clip_top    <= $signed(i_cfg_data);
                REG_CLIP_BOTTOM: r_clip_bottom <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_plot    <= i_req_type;
            r_on      <= w_on;
            r_inside  <= w_inside;
            r_addr    <= w_addr;
            r_pix_idx <= ~i_pos_x[2:0];
        end
    end

    // Frame store: clear sweep or read-modify-write
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_addr] <= 8'h00;
        end else if (i_cmd.apply && w_we) begin
            r_mem[r_addr] <= w_byte;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Advance the clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_pix_value   <= w_value;
            r_pix_written <= w_we;
        end
    end

    assign o_status.clr_last = (r_clr_addr == ADDR_W'(FRAME_DEPTH - 1));
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_pixel_value     = r_pix_value;
    assign o_pixel_written   = r_pix_written;

    // Never overwrite a result that is still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |-> !(r_out_valid && !i_out_ready))
        else $error("result overwritten before delivery");

    // A new result comes only from an apply step
    a_valid_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.apply))
        else $error("output valid without apply");

endmodule

@@ design/mono_framebuffer_pixel_plotter_unit.sv @@
// Channel   Handshake                 Payload
// --------  ------------------------  ------------------------------------
// request   i_in_valid / o_in_ready   i_req_type, i_pos_x, i_pos_y
// result    o_out_valid / i_out_ready o_pixel_value, o_pixel_written
// config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each request goes through accept, store read, and modify and write steps;
// the next is taken only after its write step, set by the single-port
// read-modify-write of the store. After reset a clearing pass zeroes the
// store, one byte a cycle; no request is accepted meanwhile, configuration
// writes are always taken. A stalled result holds the block in its write
// step; the next request may be accepted while a finished result still waits.
module mono_framebuffer_pixel_plotter_unit
    import mfpp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int ROW_BYTES     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_pixel_value,
    output logic                 o_pixel_written,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    mfpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mfpp_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ROW_BYTES     (ROW_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_value   (o_pixel_value),
        .o_pixel_written (o_pixel_written)
    );

endmodule
